### hdl/ppu_cpu_register_port_defines.svh
// assertion macros for the register port
`ifndef PPU_CPU_REGISTER_PORT_DEFINES_SVH
`define PPU_CPU_REGISTER_PORT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PCRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("register port check failed");

// next-cycle implication, checked out of reset
`define PCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("register port check failed");

`endif

### hdl/ppu_crp_pkg.sv
package ppu_crp_pkg;

    typedef enum logic [2:0] {
        REG_CTRL    = 3'd0,
        REG_MASK    = 3'd1,
        REG_STATUS  = 3'd2,
        REG_OAMADDR = 3'd3,
        REG_OAMDATA = 3'd4,
        REG_SCROLL  = 3'd5,
        REG_ADDR    = 3'd6,
        REG_DATA    = 3'd7
    } t_reg_index;

    typedef enum logic {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_STATUS,
        RES_DATA
    } t_res_kind;

    typedef enum logic [1:0] {
        VM_PATTERN,
        VM_NAME,
        VM_PALETTE
    } t_vmem;

    typedef struct packed {
        t_res_kind kind;
        t_vmem     sel;
        logic      gray;
    } t_s1;

    localparam logic       CFG_MIRRORING = 1'b0;
    localparam logic [7:0] PAL_MASK      = 8'h3F;
    localparam logic [7:0] GRAY_MASK     = 8'h30;
    localparam logic [7:0] STATUS_MASK   = 8'h1F;
    localparam logic [5:0] PAL_PAGE      = 6'h3F;
    localparam logic [15:0] STEP_WIDE    = 16'd32;
    localparam logic [15:0] STEP_NARROW  = 16'd1;

    localparam int PAT_DEPTH  = 8192;
    localparam int NAME_DEPTH = 2048;
    localparam int PAL_DEPTH  = 32;

endpackage

### hdl/ppu_cpu_register_port.sv
// channel   direction  handshake                 payload
// access    in         i_in_valid / o_in_ready   i_req_type, i_reg_index, i_write_data
// result    out        o_out_valid / i_out_ready o_read_data
// config    in         psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// one access per cycle while the output is not stalled; each result passes through stage one and the output register
// video memory is read at the access beat and the data lands in the next cycle in stage one
// read buffer and result are settled as stage one moves to the output register
// synchronous active-low reset clears control state; memories are not cleared
// a stalled output holds stage one, which then holds the input
`include "ppu_cpu_register_port_defines.svh"

module ppu_cpu_register_port (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ppu_crp_pkg::*;

    logic        r_mirroring;
    logic [7:0]  r_control;
    logic [7:0]  r_mask;
    logic        r_write_toggle;
    logic [7:0]  r_read_buffer;
    logic [14:0] r_temp_address;
    logic [15:0] r_video_address;
    logic        r_s1_valid;
    t_s1         r_s1;
    logic        r_out_valid;
    logic [7:0]  r_out_data;

    logic [7:0]  pattern_mem [PAT_DEPTH];
    logic [7:0]  name_mem    [NAME_DEPTH];
    logic [7:0]  palette_mem [PAL_DEPTH];
    logic [7:0]  r_pat_rdata;
    logic [7:0]  r_name_rdata;
    logic [7:0]  r_pal_rdata;

    logic        in_beat;
    logic        s1_move;
    logic        cfg_write;
    logic [13:0] vaddr;
    t_vmem       vsel;
    logic [12:0] pat_index;
    logic [10:0] name_index;
    logic [4:0]  pal_index;
    logic        data_read;
    logic        data_write;
    logic [15:0] addr_step;
    t_reg_index  reg_sel;
    t_s1         n_s1;
    logic        n_write_toggle;
    logic [14:0] n_temp_address;
    logic [15:0] n_video_address;
    logic [7:0]  n_control;
    logic [7:0]  n_mask;
    logic [7:0]  mem_byte;
    logic [7:0]  n_out_data;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == CFG_MIRRORING) ? {31'd0, r_mirroring} : 32'd0;

    assign s1_move    = r_s1_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_s1_valid | s1_move;
    assign in_beat    = i_in_valid & o_in_ready;

    assign reg_sel    = t_reg_index'(i_reg_index);
    assign data_read  = in_beat & (i_req_type == REQ_READ) & (reg_sel == REG_DATA);
    assign data_write = in_beat & (i_req_type == REQ_WRITE) & (reg_sel == REG_DATA);
    assign addr_step  = r_control[2] ? STEP_WIDE : STEP_NARROW;

    // video address decode
    assign vaddr      = r_video_address[13:0];
    assign pat_index  = vaddr[12:0];
    assign name_index = {(r_mirroring ? vaddr[11] : vaddr[10]), vaddr[9:0]};
    assign pal_index  = (vaddr[4] && vaddr[1:0] == 2'b00) ? {1'b0, vaddr[3:0]} : vaddr[4:0];

    always_comb begin
        if (!vaddr[13]) begin
            vsel = VM_PATTERN;
        end else if (vaddr[13:8] == PAL_PAGE) begin
            vsel = VM_PALETTE;
        end else begin
            vsel = VM_NAME;
        end
    end

    // register side effects at the access beat
    always_comb begin
        n_s1            = '{kind: RES_ZERO, sel: vsel, gray: r_mask[0]};
        n_write_toggle  = r_write_toggle;
        n_temp_address  = r_temp_address;
        n_video_address = r_video_address;
        n_control       = r_control;
        n_mask          = r_mask;
        if (i_req_type == REQ_READ) begin
            unique case (reg_sel)
                REG_STATUS: begin
                    n_s1.kind      = RES_STATUS;
                    n_write_toggle = 1'b0;
                end
                REG_DATA: begin
                    n_s1.kind       = RES_DATA;
                    n_video_address = r_video_address + addr_step;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (reg_sel)
                REG_CTRL: begin
                    n_control             = i_write_data;
                    n_temp_address[11:10] = i_write_data[1:0];
                end
                REG_MASK: begin
                    n_mask = i_write_data;
                end
                REG_SCROLL: begin
                    if (!r_write_toggle) begin
                        n_temp_address[4:0] = i_write_data[7:3];
                    end else begin
                        n_temp_address[14:12] = i_write_data[2:0];
                        n_temp_address[9:5]   = i_write_data[7:3];
                    end
                    n_write_toggle = ~r_write_toggle;
                end
                REG_ADDR: begin
                    if (!r_write_toggle) begin
                        n_temp_address[14:8] = {1'b0, i_write_data[5:0]};
                    end else begin
                        n_temp_address[7:0] = i_write_data;
                        n_video_address     = {1'b0, r_temp_address[14:8], i_write_data};
                    end
                    n_write_toggle = ~r_write_toggle;
                end
                REG_DATA: begin
                    n_video_address = r_video_address + addr_step;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_write && vsel == VM_PATTERN) begin
            pattern_mem[pat_index] <= i_write_data;
        end
        if (data_read && vsel == VM_PATTERN) begin
            r_pat_rdata <= pattern_mem[pat_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_write && vsel == VM_NAME) begin
            name_mem[name_index] <= i_write_data;
        end
        if (data_read && vsel == VM_NAME) begin
            r_name_rdata <= name_mem[name_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_write && vsel == VM_PALETTE) begin
            palette_mem[pal_index] <= i_write_data;
        end
        if (data_read && vsel == VM_PALETTE) begin
            r_pal_rdata <= palette_mem[pal_index];
        end
    end

    // stage one: finish the read and settle the buffer
    always_comb begin
        case (r_s1.sel)
            VM_PATTERN: mem_byte = r_pat_rdata;
            VM_NAME:    mem_byte = r_name_rdata;
            default:    mem_byte = r_pal_rdata & (r_s1.gray ? GRAY_MASK : PAL_MASK);
        endcase
        case (r_s1.kind)
            RES_STATUS: n_out_data = r_read_buffer & STATUS_MASK;
            RES_DATA:   n_out_data = (r_s1.sel == VM_PALETTE) ? mem_byte : r_read_buffer;
            default:    n_out_data = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirroring     <= 1'b0;
            r_control       <= 8'd0;
            r_mask          <= 8'd0;
            r_write_toggle  <= 1'b0;
            r_read_buffer   <= 8'd0;
            r_temp_address  <= 15'd0;
            r_video_address <= 16'd0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == CFG_MIRRORING) begin
                r_mirroring <= pwdata[0];
            end
            if (in_beat) begin
                r_control       <= n_control;
                r_mask          <= n_mask;
                r_write_toggle  <= n_write_toggle;
                r_temp_address  <= n_temp_address;
                r_video_address <= n_video_address;
            end
            if (s1_move && r_s1.kind == RES_DATA) begin
                r_read_buffer <= mem_byte;
            end
            if (in_beat) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    `PCRP_ASSERT_NOW(a_hold_when_blocked, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !i_out_ready, !o_in_ready)
    `PCRP_ASSERT_NEXT(a_status_clears_toggle, i_clk, i_rst_n,
        in_beat && i_req_type == REQ_READ && reg_sel == REG_STATUS, !r_write_toggle)
    `PCRP_ASSERT_NEXT(a_data_steps_address, i_clk, i_rst_n,
        in_beat && reg_sel == REG_DATA,
        r_video_address == 16'($past(r_video_address) + $past(addr_step)))
    `PCRP_ASSERT_NEXT(a_write_reads_zero, i_clk, i_rst_n,
        s1_move && r_s1.kind == RES_ZERO, o_out_valid && o_read_data == 8'd0)

endmodule

### tb/sv/ppu_crp_checker.sv
`timescale 1ns / 100ps

module ppu_crp_checker
    import ppu_crp_pkg::*;
#(
    parameter logic [2:0] MIRROR_ADDR = 3'd0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_req_type,
    input  logic [2:0] i_reg_index,
    input  logic [7:0] i_write_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_read_data,
    input  logic       i_psel,
    input  logic       i_penable,
    input  logic       i_pwrite,
    input  logic       i_pready,
    input  logic [2:0] i_paddr,
    input  logic [31:0] i_pwdata,
    output int         o_pending,
    output int         o_errors
);

    logic [7:0]  pattern_mem [PAT_DEPTH];
    logic [7:0]  name_mem    [NAME_DEPTH];
    logic [7:0]  palette_mem [PAL_DEPTH];
    logic        mirroring;
    logic        write_toggle;
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [7:0]  read_buffer;
    logic [14:0] temp_addr;
    logic [15:0] video_addr;
    logic [7:0]  read_data_q [$];
    int          errors = 0;

    function automatic logic [10:0] name_slot(input logic [13:0] a);
        return {(mirroring ? a[11] : a[10]), a[9:0]};
    endfunction

    function automatic logic [4:0] palette_slot(input logic [4:0] a);
        return (a[4] && a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a;
    endfunction

    function automatic logic [7:0] vram_fetch(input logic [15:0] va);
        logic [13:0] a;
        a = va[13:0];
        if (a < 14'h2000)
            return pattern_mem[a[12:0]];
        if (a < {PAL_PAGE, 8'h00})
            return name_mem[name_slot(a)];
        return palette_mem[palette_slot(a[4:0])] & (mask_q[0] ? GRAY_MASK : PAL_MASK);
    endfunction

    function automatic void vram_store(input logic [15:0] va, input logic [7:0] d);
        logic [13:0] a;
        a = va[13:0];
        if (a < 14'h2000)
            pattern_mem[a[12:0]] = d;
        else if (a < {PAL_PAGE, 8'h00})
            name_mem[name_slot(a)] = d;
        else
            palette_mem[palette_slot(a[4:0])] = d;
    endfunction

    function automatic void step_video_addr();
        video_addr = video_addr + (ctrl_q[2] ? STEP_WIDE : STEP_NARROW);
    endfunction

    function automatic logic [7:0] compute_read_data(input t_req_type rt, input t_reg_index ri,
                                                     input logic [7:0] d);
        logic [7:0] rd;
        rd = '0;
        if (rt == REQ_READ) begin
            if (ri == REG_STATUS) begin
                write_toggle = 1'b0;
                rd = read_buffer & STATUS_MASK;
            end else if (ri == REG_DATA) begin
                rd = read_buffer;
                read_buffer = vram_fetch(video_addr);
                if (video_addr[13:0] >= {PAL_PAGE, 8'h00})
                    rd = read_buffer;
                step_video_addr();
            end
        end else begin
            case (ri)
                REG_CTRL: begin
                    ctrl_q = d;
                    temp_addr[11:10] = d[1:0];
                end
                REG_MASK: begin
                    mask_q = d;
                end
                REG_SCROLL: begin
                    if (!write_toggle) begin
                        temp_addr[4:0] = d[7:3];
                    end else begin
                        temp_addr[14:12] = d[2:0];
                        temp_addr[9:5]   = d[7:3];
                    end
                    write_toggle = ~write_toggle;
                end
                REG_ADDR: begin
                    if (!write_toggle) begin
                        temp_addr[14:8] = {1'b0, d[5:0]};
                    end else begin
                        temp_addr[7:0] = d;
                        video_addr = {1'b0, temp_addr};
                    end
                    write_toggle = ~write_toggle;
                end
                REG_DATA: begin
                    vram_store(video_addr, d);
                    step_video_addr();
                end
                default: begin
                end
            endcase
        end
        return rd;
    endfunction

    always @(posedge i_clk) begin : check_proc
        logic [7:0] want;
        if (!i_rst_n) begin
            mirroring    = 1'b0;
            write_toggle = 1'b0;
            ctrl_q       = '0;
            mask_q       = '0;
            read_buffer  = '0;
            temp_addr    = '0;
            video_addr   = '0;
            read_data_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MIRROR_ADDR)
                mirroring = i_pwdata[0];
            if (i_out_valid && i_out_ready) begin
                if (read_data_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %02h",
                             $time, i_read_data);
                    errors++;
                end else begin
                    want = read_data_q.pop_front();
                    if (i_read_data !== want) begin
                        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                                 $time, want, i_read_data);
                        errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                read_data_q.push_back(compute_read_data(t_req_type'(i_req_type),
                                                        t_reg_index'(i_reg_index),
                                                        i_write_data));
        end
        o_pending <= read_data_q.size();
        o_errors  <= errors;
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ppu_crp_pkg::*;

    localparam logic [2:0] MIRROR_ADDR = 3'd0;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SWEEP_LEN   = 40;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        req_type    = 1'b0;
    logic [2:0]  reg_index   = '0;
    logic [7:0]  write_data  = '0;
    logic        out_ready   = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic        idle_on     = 1'b1;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  read_data;
    logic [31:0] prdata;
    logic        pready;
    int          pending;
    int          errors;
    int          cycle_count = 0;
    int          stall_left  = 0;
    int          issued      = 0;

    // stimulus-side view of the address logic, so that no unwritten entry is read
    logic        trk_mirroring = 1'b0;
    logic        trk_toggle    = 1'b0;
    logic        trk_wide      = 1'b0;
    logic [14:0] trk_tmp       = '0;
    logic [15:0] trk_va        = '0;
    bit          written [PAT_DEPTH + NAME_DEPTH + PAL_DEPTH];

    always #6 clk = ~clk;

    ppu_cpu_register_port u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_reg_index  (reg_index),
        .i_write_data (write_data),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_read_data  (read_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    ppu_crp_checker #(.MIRROR_ADDR(MIRROR_ADDR)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_reg_index  (reg_index),
        .i_write_data (write_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_read_data  (read_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic int vram_slot(input logic [15:0] va);
        logic [13:0] a;
        a = va[13:0];
        if (a < 14'h2000)
            return int'(a);
        if (a < {PAL_PAGE, 8'h00})
            return PAT_DEPTH + int'({(trk_mirroring ? a[11] : a[10]), a[9:0]});
        if (a[4] && a[1:0] == 2'b00)
            return PAT_DEPTH + NAME_DEPTH + int'(a[3:0]);
        return PAT_DEPTH + NAME_DEPTH + int'(a[4:0]);
    endfunction

    task automatic track(input t_req_type rt, input t_reg_index ri, input logic [7:0] d);
        if (rt == REQ_READ) begin
            if (ri == REG_STATUS)
                trk_toggle = 1'b0;
            else if (ri == REG_DATA)
                trk_va = trk_va + (trk_wide ? STEP_WIDE : STEP_NARROW);
        end else begin
            case (ri)
                REG_CTRL: begin
                    trk_wide = d[2];
                    trk_tmp[11:10] = d[1:0];
                end
                REG_SCROLL: begin
                    if (!trk_toggle) begin
                        trk_tmp[4:0] = d[7:3];
                    end else begin
                        trk_tmp[14:12] = d[2:0];
                        trk_tmp[9:5]   = d[7:3];
                    end
                    trk_toggle = ~trk_toggle;
                end
                REG_ADDR: begin
                    if (!trk_toggle) begin
                        trk_tmp[14:8] = {1'b0, d[5:0]};
                    end else begin
                        trk_tmp[7:0] = d;
                        trk_va = {1'b0, trk_tmp};
                    end
                    trk_toggle = ~trk_toggle;
                end
                REG_DATA: begin
                    written[vram_slot(trk_va)] = 1'b1;
                    trk_va = trk_va + (trk_wide ? STEP_WIDE : STEP_NARROW);
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic send_beat(input t_req_type rt, input t_reg_index ri, input logic [7:0] d);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rt;
        reg_index  <= ri;
        write_data <= d;
        do @(posedge clk); while (!in_ready);
        issued++;
    endtask

    // a data read of an entry never written becomes a data write
    task automatic access(input t_req_type rt, input t_reg_index ri, input logic [7:0] d);
        t_req_type kind;
        kind = rt;
        if (rt == REQ_READ && ri == REG_DATA && !written[vram_slot(trk_va)])
            kind = REQ_WRITE;
        track(kind, ri, d);
        send_beat(kind, ri, d);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mirroring(input logic m);
        hold_until_drained();
        repeat (4) @(posedge clk);
        apb_write(MIRROR_ADDR, {31'b0, m});
        trk_mirroring = m;
    endtask

    function automatic logic [7:0] pick_page();
        logic [7:0] pg;
        case ($urandom_range(0, 3))
            0:       pg = 8'($urandom_range(8'h00, 8'h1F));
            1:       pg = 8'($urandom_range(8'h20, 8'h3E));
            2:       pg = 8'h3F;
            default: pg = 8'($urandom_range(0, 255));
        endcase
        pg[7:6] = 2'($urandom_range(0, 3));
        return pg;
    endfunction

    task automatic vram_burst();
        logic [7:0] hi;
        logic [7:0] lo;
        int n;
        hi = pick_page();
        lo = 8'($urandom_range(0, 255));
        n  = $urandom_range(1, 8);
        if ($urandom_range(0, 3) == 0)
            access(REQ_WRITE, REG_CTRL, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) != 0)
            access(REQ_READ, REG_STATUS, 8'($urandom_range(0, 255)));
        access(REQ_WRITE, REG_ADDR, hi);
        access(REQ_WRITE, REG_ADDR, lo);
        repeat (n) access(REQ_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
            access(REQ_WRITE, REG_MASK, 8'($urandom_range(0, 255)));
        access(REQ_WRITE, REG_ADDR, hi);
        access(REQ_WRITE, REG_ADDR, lo);
        repeat (n + 1) access(REQ_READ, REG_DATA, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_phase(input int n_items, input bit pause_midway);
        int first;
        first = issued;
        while (issued - first < n_items) begin
            if (pause_midway && issued - first >= n_items / 2) begin
                pause_midway = 1'b0;
                hold_until_drained();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: vram_burst();
                6, 7: access(t_req_type'($urandom_range(0, 1)),
                             t_reg_index'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)));
                8: begin
                    access(REQ_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                    access(REQ_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                    access(REQ_WRITE, REG_CTRL, 8'($urandom_range(0, 255)));
                    access(REQ_WRITE, REG_MASK, 8'($urandom_range(0, 255)));
                end
                default: begin
                    // half an address or scroll pair flips the toggle
                    if ($urandom_range(0, 1) == 0)
                        access(REQ_WRITE, REG_ADDR, 8'($urandom_range(0, 255)));
                    else
                        access(REQ_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mirroring(1'b0);
        for (int r = 0; r < 7; r++)
            access(REQ_READ, t_reg_index'(r), 8'hFF);
        access(REQ_WRITE, REG_STATUS, 8'hFF);
        access(REQ_WRITE, REG_OAMADDR, 8'hFF);
        access(REQ_WRITE, REG_OAMDATA, 8'hFF);
        access(REQ_WRITE, REG_SCROLL, 8'hFF);
        access(REQ_WRITE, REG_SCROLL, 8'h00);
        access(REQ_WRITE, REG_CTRL, 8'hFF);
        access(REQ_WRITE, REG_CTRL, 8'h00);
        access(REQ_WRITE, REG_ADDR, 8'hFF);
        access(REQ_WRITE, REG_ADDR, 8'h00);
        access(REQ_WRITE, REG_DATA, 8'hFF);
        access(REQ_WRITE, REG_DATA, 8'h00);
        // backdrop mirror, then grayscale
        access(REQ_WRITE, REG_ADDR, 8'h3F);
        access(REQ_WRITE, REG_ADDR, 8'h10);
        access(REQ_READ, REG_DATA, 8'h00);
        access(REQ_WRITE, REG_MASK, 8'hFF);
        access(REQ_WRITE, REG_ADDR, 8'h3F);
        access(REQ_WRITE, REG_ADDR, 8'h00);
        access(REQ_READ, REG_DATA, 8'h00);
        access(REQ_READ, REG_STATUS, 8'h00);
        access(REQ_WRITE, REG_MASK, 8'h00);
        // vertical mirroring: 0x2800 aliases 0x2000
        access(REQ_WRITE, REG_ADDR, 8'h20);
        access(REQ_WRITE, REG_ADDR, 8'h00);
        access(REQ_WRITE, REG_DATA, 8'hA5);
        access(REQ_WRITE, REG_ADDR, 8'h28);
        access(REQ_WRITE, REG_ADDR, 8'h00);
        access(REQ_READ, REG_DATA, 8'h00);
        access(REQ_READ, REG_STATUS, 8'h00);

        set_mirroring(1'b1);
        // horizontal mirroring: 0x2400 and 0x3000 alias 0x2000
        access(REQ_READ, REG_STATUS, 8'h00);
        access(REQ_WRITE, REG_ADDR, 8'h20);
        access(REQ_WRITE, REG_ADDR, 8'h00);
        access(REQ_WRITE, REG_DATA, 8'h3C);
        access(REQ_WRITE, REG_ADDR, 8'h24);
        access(REQ_WRITE, REG_ADDR, 8'h00);
        access(REQ_READ, REG_DATA, 8'h00);
        access(REQ_WRITE, REG_ADDR, 8'h30);
        access(REQ_WRITE, REG_ADDR, 8'h00);
        access(REQ_READ, REG_DATA, 8'h00);
        random_phase(110, 1'b1);

        set_mirroring(1'b0);
        // step 32 from the top of the palette through the 0x4000 fold
        access(REQ_WRITE, REG_CTRL, 8'h04);
        access(REQ_READ, REG_STATUS, 8'h00);
        access(REQ_WRITE, REG_ADDR, 8'h3F);
        access(REQ_WRITE, REG_ADDR, 8'hE0);
        repeat (SWEEP_LEN)
            access(t_req_type'($urandom_range(0, 1)), REG_DATA, 8'($urandom_range(0, 255)));
        random_phase(110, 1'b0);

        set_mirroring(1'($urandom_range(0, 1)));
        idle_on <= 1'b0;
        random_phase(110, 1'b0);

        hold_until_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
